// ===== src/rsc_pkg.sv =====
// Shared widths, codes and constants for the ray-sphere closest-hit block.
package rsc_pkg;

   localparam int FIELD_W   = 32;
   localparam int RADIUS_W  = 31;
   localparam int INDEX_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int FRAC_BITS = 16;
   localparam int MUL_DIGIT = 16;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_CAST = 1'b1;

   localparam logic [FIELD_W-1:0] T_MAX = 32'h7FFF_FFFF;

endpackage

// ===== src/rsc_mul.sv =====
// Multi-cycle signed multiplier, one digit of the multiplier per cycle.
module rsc_mul #(
   parameter int MW = 51
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [MW-1:0]   op_a,
   input  logic signed [MW-1:0]   op_b,
   output logic                   done,
   output logic signed [2*MW-1:0] product
);

   localparam int DIG   = rsc_pkg::MUL_DIGIT;
   localparam int STEPS = (MW + DIG - 1) / DIG;
   localparam int LW    = STEPS * DIG;
   localparam int AW    = MW + LW;
   localparam int CNTW  = $clog2(STEPS + 1);

   logic [MW-1:0]          mcand_ff;
   logic [LW-1:0]          mplier_ff;
   logic [AW-1:0]          acc_ff;
   logic                   neg_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [CNTW-1:0]        cnt_ff;
   logic signed [2*MW-1:0] product_ff;

   logic [MW-1:0]     mag_a;
   logic [MW-1:0]     mag_b;
   logic [MW+DIG-1:0] partial;
   logic [2*MW-1:0]   acc_lo;

   assign mag_a   = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
   assign mag_b   = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);
   assign partial = mcand_ff * mplier_ff[LW-1 -: DIG];
   assign acc_lo  = acc_ff[2*MW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mcand_ff  <= mag_a;
            mplier_ff <= LW'(mag_b);
            acc_ff    <= '0;
            neg_ff    <= op_a[MW-1] ^ op_b[MW-1];
            cnt_ff    <= '0;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff == CNTW'(STEPS)) begin
               // apply the sign once the magnitude is complete
               product_ff <= $signed(neg_ff ? (~acc_lo + 1'b1) : acc_lo);
               busy_ff    <= 1'b0;
               done_ff    <= 1'b1;
            end else begin
               acc_ff    <= (acc_ff << DIG) + AW'(partial);
               mplier_ff <= mplier_ff << DIG;
               cnt_ff    <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

// ===== src/rsc_sqrt.sv =====
// Restoring integer square root, one result bit per cycle.
module rsc_sqrt #(
   parameter int SW = 50
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [2*SW-1:0] radicand,
   output logic            done,
   output logic [SW-1:0]   root
);

   localparam int CNTW = $clog2(SW + 1);

   logic [2*SW-1:0] rad_ff;
   logic [SW+1:0]   rem_ff;
   logic [SW-1:0]   root_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [SW+3:0] trial;
   logic [SW+3:0] test;

   assign trial = {rem_ff, rad_ff[2*SW-1 -: 2]};
   assign test  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= test) begin
               rem_ff  <= (SW+2)'(trial - test);
               root_ff <= {root_ff[SW-2:0], 1'b1};
            end else begin
               rem_ff  <= trial[SW+1:0];
               root_ff <= {root_ff[SW-2:0], 1'b0};
            end
            rad_ff <= rad_ff << 2;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(SW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== src/rsc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rsc_div #(
   parameter int NW = 67,
   parameter int VW = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CNTW = $clog2(NW + 1);

   logic [NW-1:0]   num_ff;
   logic [VW-1:0]   den_ff;
   logic [VW-1:0]   rem_ff;
   logic [NW-1:0]   quo_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [VW:0] shifted;
   logic        fits;

   assign shifted = {rem_ff, num_ff[NW-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? VW'(shifted - {1'b0, den_ff}) : shifted[VW-1:0];
            quo_ff <= {quo_ff[NW-2:0], fits};
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/ray_sphere_closest_hit.sv =====
// Ray-sphere closest hit: sphere table memory, per-entry sequencer and result register.
// Load item: written to the table when its index is below MAX_SPHERES, no result.
// Cast item: tests n = min(sphere_count, MAX_SPHERES) entries in turn; per entry it makes
// nine passes through the shared digit multiplier and, unless the discriminant is negative,
// runs the 50-step root and two bit-serial divides (67 quotient bits each) at the default widths.
// One item at a time; a finished result waits in the output register while the next item enters.
// Synchronous reset clears control and sphere_count; table entries are undefined until loaded.
module ray_sphere_closest_hit #(
   parameter int MAX_SPHERES = 64,
   parameter int COORD_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [rsc_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_pos_x,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_pos_y,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_pos_z,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_dir_x,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_dir_y,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_dir_z,
   input  logic [rsc_pkg::RADIUS_W-1:0]         req_radius,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_t_lower,
   input  logic signed [rsc_pkg::FIELD_W-1:0]   req_t_upper,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [rsc_pkg::INDEX_W-1:0]          rsp_hit_index,
   output logic signed [rsc_pkg::FIELD_W-1:0]   rsp_hit_t,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rsc_pkg::COUNT_W-1:0]          csr_data
);

   localparam int FW   = rsc_pkg::FIELD_W;
   localparam int RW   = rsc_pkg::RADIUS_W;
   localparam int IXW  = rsc_pkg::INDEX_W;
   localparam int CTW  = rsc_pkg::COUNT_W;
   localparam int CW   = COORD_BITS < 32 ? COORD_BITS : 32;
   localparam int PSH  = CW > 24 ? 2 * CW - 48 : 0;
   localparam int ARW  = 2 * CW;
   localparam int BRW  = 2 * CW + 2;
   localparam int CRW  = 2 * CW + 3;
   localparam int AQW  = ARW - PSH;
   localparam int BQW  = BRW - PSH;
   localparam int CQW  = CRW - PSH;
   localparam int MW   = CQW;
   localparam int PW   = 2 * MW;
   localparam int DW   = 4 * CW + 4 - 2 * PSH;
   localparam int SW   = DW / 2;
   localparam int NUMW = SW + 2;
   localparam int NW   = SW + 1 + rsc_pkg::FRAC_BITS;
   localparam int MAW  = MAX_SPHERES > 1 ? $clog2(MAX_SPHERES) : 1;
   localparam int CNTW = $clog2(MAX_SPHERES + 1);
   localparam int WORD_W = 3 * FW + RW;
   localparam int CX_LSB = RW + 2 * FW;
   localparam int CY_LSB = RW + FW;
   localparam int CZ_LSB = RW;

   localparam logic [NW-1:0] SAT_NEG = NW'(33'h1_0000_0000 >> 1);
   localparam logic [NW-1:0] SAT_POS = NW'(rsc_pkg::T_MAX);

   typedef enum logic [3:0] {
      S_IDLE, S_AMUL, S_ACHK, S_FETCH, S_MUL, S_CHK,
      S_SQRT, S_DIV0, S_DIV1, S_NEXT, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_BX, OP_BY, OP_BZ, OP_CX, OP_CY, OP_CZ, OP_RR, OP_BB, OP_AC
   } op_type;

   state_type state_ff;
   op_type    op_ff;

   logic [CTW-1:0]        count_ff;
   logic signed [CW-1:0]  org_ff [3];
   logic signed [CW-1:0]  dir_ff [3];
   logic signed [FW-1:0]  t_lower_ff;
   logic signed [FW-1:0]  t_upper_ff;
   logic                  unbounded_ff;
   logic [CNTW-1:0]       n_ff;
   logic [CNTW-1:0]       idx_ff;
   logic [ARW-1:0]        a_acc_ff;
   logic signed [BRW-1:0] b_acc_ff;
   logic signed [CRW-1:0] c_acc_ff;
   logic signed [DW-1:0]  disc_ff;
   logic                  found_ff;
   logic signed [FW-1:0]  best_t_ff;
   logic [IXW-1:0]        best_i_ff;
   logic                  mul_start_ff;
   logic                  sqrt_start_ff;
   logic                  div_start_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [IXW-1:0]        rsp_hit_index_ff;
   logic signed [FW-1:0]  rsp_hit_t_ff;

   logic [WORD_W-1:0] sphere_mem [MAX_SPHERES];
   logic [WORD_W-1:0] mem_q_ff;

   // table write path
   logic                accept;
   logic [CNTW+IXW-1:0] widx;
   logic                mem_we;

   assign accept = req_valid && !req_stall;
   assign widx   = {{CNTW{1'b0}}, req_entry_index};
   assign mem_we = accept && (req_kind == rsc_pkg::KIND_LOAD) &&
                   (widx < (CNTW+IXW)'(MAX_SPHERES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sphere_mem[widx[MAW-1:0]] <= {req_pos_x, req_pos_y, req_pos_z, req_radius};
      end
      mem_q_ff <= sphere_mem[idx_ff[MAW-1:0]];
   end

   // entry count clamped to the table size
   logic [CNTW+CTW-1:0] count_ext;
   logic [CNTW-1:0]     n_in;

   assign count_ext = {{CNTW{1'b0}}, count_ff};
   assign n_in = (count_ext > (CNTW+CTW)'(MAX_SPHERES)) ? CNTW'(MAX_SPHERES)
                                                       : CNTW'(count_ext);

   // offsets from the current centre to the ray origin
   logic signed [CW:0]   oc [3];
   logic [CW-2:0]        rad;

   assign oc[0] = (CW+1)'(org_ff[0]) - (CW+1)'($signed(mem_q_ff[CX_LSB +: CW]));
   assign oc[1] = (CW+1)'(org_ff[1]) - (CW+1)'($signed(mem_q_ff[CY_LSB +: CW]));
   assign oc[2] = (CW+1)'(org_ff[2]) - (CW+1)'($signed(mem_q_ff[CZ_LSB +: CW]));
   assign rad   = mem_q_ff[CW-2:0];

   logic [AQW-1:0]        a_q;
   logic signed [BQW-1:0] b_q;
   logic signed [CQW-1:0] c_q;

   assign a_q = AQW'(a_acc_ff >> PSH);
   assign b_q = BQW'(b_acc_ff >>> PSH);
   assign c_q = CQW'(c_acc_ff >>> PSH);

   // multiplier operand selection
   logic signed [MW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic                 mul_done;
   logic signed [PW-1:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_AMUL) begin
         case (op_ff)
            OP_BX:   begin mul_a = MW'(dir_ff[0]); mul_b = MW'(dir_ff[0]); end
            OP_BY:   begin mul_a = MW'(dir_ff[1]); mul_b = MW'(dir_ff[1]); end
            default: begin mul_a = MW'(dir_ff[2]); mul_b = MW'(dir_ff[2]); end
         endcase
      end else begin
         case (op_ff)
            OP_BX:   begin mul_a = MW'(oc[0]); mul_b = MW'(dir_ff[0]); end
            OP_BY:   begin mul_a = MW'(oc[1]); mul_b = MW'(dir_ff[1]); end
            OP_BZ:   begin mul_a = MW'(oc[2]); mul_b = MW'(dir_ff[2]); end
            OP_CX:   begin mul_a = MW'(oc[0]); mul_b = MW'(oc[0]); end
            OP_CY:   begin mul_a = MW'(oc[1]); mul_b = MW'(oc[1]); end
            OP_CZ:   begin mul_a = MW'(oc[2]); mul_b = MW'(oc[2]); end
            OP_RR:   begin
               mul_a = MW'($signed({1'b0, rad}));
               mul_b = MW'($signed({1'b0, rad}));
            end
            OP_BB:   begin mul_a = MW'(b_q); mul_b = MW'(b_q); end
            OP_AC:   begin mul_a = MW'($signed({1'b0, a_q})); mul_b = c_q; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   rsc_mul #(.MW(MW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   logic          sqrt_done;
   logic [SW-1:0] sqrt_root;

   rsc_sqrt #(.SW(SW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (disc_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // numerators -B + s and -B - s, scaled for the Q16.16 quotient
   logic signed [SW:0]     s_ext;
   logic signed [NUMW-1:0] num0;
   logic signed [NUMW-1:0] num1;
   logic signed [NUMW-1:0] num_sel;
   logic                   num_neg;
   logic [SW:0]            num_mag;
   logic [NW-1:0]          dividend;
   logic                   div_done;
   logic [NW-1:0]          div_q;

   assign s_ext    = $signed({1'b0, sqrt_root});
   assign num0     = NUMW'(s_ext) - NUMW'(b_q);
   assign num1     = -(NUMW'(b_q) + NUMW'(s_ext));
   assign num_sel  = (state_ff == S_DIV1) ? num1 : num0;
   assign num_neg  = num_sel[NUMW-1];
   assign num_mag  = num_neg ? (SW+1)'(-num_sel) : (SW+1)'(num_sel);
   assign dividend = {num_mag, {rsc_pkg::FRAC_BITS{1'b0}}};

   rsc_div #(.NW(NW), .VW(AQW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dividend),
      .divisor  (a_q),
      .done     (div_done),
      .quotient (div_q)
   );

   // saturate the root and test it against the window and the best so far
   logic [FW-1:0]        mag32;
   logic signed [FW-1:0] root_t;
   logic                 cand_ok;
   logic [CNTW+IXW-1:0]  idx_wide;

   always_comb begin
      if (num_neg) begin
         mag32  = (div_q > SAT_NEG) ? FW'(SAT_NEG) : div_q[FW-1:0];
         root_t = $signed(-mag32);
      end else begin
         mag32  = (div_q > SAT_POS) ? rsc_pkg::T_MAX : div_q[FW-1:0];
         root_t = $signed(mag32);
      end
   end

   assign cand_ok = (t_lower_ff < root_t) && (unbounded_ff || (root_t < t_upper_ff)) &&
                    (!found_ff || (root_t < best_t_ff));
   assign idx_wide = {{IXW{1'b0}}, idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_BX;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         mul_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         n_ff          <= '0;
      end else begin
         mul_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         if (csr_valid) begin
            count_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && (req_kind == rsc_pkg::KIND_CAST)) begin
                  org_ff[0]    <= req_pos_x[CW-1:0];
                  org_ff[1]    <= req_pos_y[CW-1:0];
                  org_ff[2]    <= req_pos_z[CW-1:0];
                  dir_ff[0]    <= req_dir_x[CW-1:0];
                  dir_ff[1]    <= req_dir_y[CW-1:0];
                  dir_ff[2]    <= req_dir_z[CW-1:0];
                  t_lower_ff   <= req_t_lower;
                  t_upper_ff   <= req_t_upper;
                  unbounded_ff <= req_t_upper == rsc_pkg::T_MAX;
                  n_ff         <= n_in;
                  a_acc_ff     <= '0;
                  found_ff     <= 1'b0;
                  best_t_ff    <= rsc_pkg::T_MAX;
                  best_i_ff    <= '0;
                  op_ff        <= OP_BX;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_AMUL;
               end
            end
            S_AMUL: begin
               if (mul_done) begin
                  a_acc_ff <= a_acc_ff + ARW'(mul_p);
                  if (op_ff == OP_BZ) begin
                     state_ff <= S_ACHK;
                  end else begin
                     op_ff        <= op_type'(op_ff + 4'd1);
                     mul_start_ff <= 1'b1;
                  end
               end
            end
            S_ACHK: begin
               // a degenerate direction misses every entry; an empty count also ends the search
               idx_ff <= '0;
               if ((a_q == '0) || (n_ff == '0)) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               op_ff        <= OP_BX;
               b_acc_ff     <= '0;
               c_acc_ff     <= '0;
               mul_start_ff <= 1'b1;
               state_ff     <= S_MUL;
            end
            S_MUL: begin
               if (mul_done) begin
                  case (op_ff)
                     OP_BX, OP_BY, OP_BZ: b_acc_ff <= b_acc_ff + BRW'(mul_p);
                     OP_CX, OP_CY, OP_CZ: c_acc_ff <= c_acc_ff + CRW'(mul_p);
                     OP_RR:               c_acc_ff <= c_acc_ff - CRW'(mul_p);
                     OP_BB:               disc_ff  <= DW'(mul_p);
                     OP_AC:               disc_ff  <= disc_ff - DW'(mul_p);
                     default:             ;
                  endcase
                  if (op_ff == OP_AC) begin
                     state_ff <= S_CHK;
                  end else begin
                     op_ff        <= op_type'(op_ff + 4'd1);
                     mul_start_ff <= 1'b1;
                  end
               end
            end
            S_CHK: begin
               // negative discriminant: drop the entry
               if (disc_ff[DW-1]) begin
                  state_ff <= S_NEXT;
               end else begin
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV0;
               end
            end
            S_DIV0: begin
               if (div_done) begin
                  if (cand_ok) begin
                     found_ff  <= 1'b1;
                     best_t_ff <= root_t;
                     best_i_ff <= idx_wide[IXW-1:0];
                  end
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV1;
               end
            end
            S_DIV1: begin
               if (div_done) begin
                  if (cand_ok) begin
                     found_ff  <= 1'b1;
                     best_t_ff <= root_t;
                     best_i_ff <= idx_wide[IXW-1:0];
                  end
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               idx_ff <= idx_ff + 1'b1;
               if (CNTW'(idx_ff + 1'b1) == n_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_hit_ff       <= found_ff;
                  rsp_hit_index_ff <= found_ff ? best_i_ff : '0;
                  rsp_hit_t_ff     <= found_ff ? best_t_ff : rsc_pkg::T_MAX;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall     = state_ff != S_IDLE;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_index = rsp_hit_index_ff;
   assign rsp_hit_t     = rsp_hit_t_ff;

`ifndef SYNTHESIS
   a_mul_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_AMUL || state_ff == S_MUL))
      else $error("multiplier finished outside a multiply state");

   a_sqrt_nonneg: assert property (@(posedge clock) disable iff (reset)
      sqrt_start_ff |-> !disc_ff[DW-1])
      else $error("square root started on a negative discriminant");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH || state_ff == S_MUL || state_ff == S_CHK ||
       state_ff == S_SQRT || state_ff == S_DIV0 || state_ff == S_DIV1 ||
       state_ff == S_NEXT) |-> (idx_ff < n_ff))
      else $error("entry index beyond tested count");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result overwrote a pending item");
`endif

endmodule
